// ----- rtl/vfc_pkg.sv -----
// Shared constants, types and helpers of the voxel face culler.
package vfc_pkg;

   localparam int MAX_EDGE    = 32;
   localparam int COORD_W     = $clog2(MAX_EDGE);
   localparam int ROW_W       = 1 << COORD_W;
   localparam int ROW_ADDR_W  = 2 * COORD_W;
   localparam int ROWS        = 1 << ROW_ADDR_W;

   localparam int VOX_W       = 5;
   localparam int VALUE_W     = 8;
   localparam int EDGE_W      = 6;
   localparam int ORIGIN_W    = 21;
   localparam int POS_W       = 22;
   localparam int KIND_W      = 3;
   localparam int NFACE       = 6;
   localparam int CMP_W       = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 72;

   localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_EDGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z   = 2'd3;

   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_code_type;

   typedef enum logic [KIND_W-1:0] {
      FACE_LEFT  = 3'd0,
      FACE_RIGHT = 3'd1,
      FACE_DOWN  = 3'd2,
      FACE_UP    = 3'd3,
      FACE_FRONT = 3'd4,
      FACE_BACK  = 3'd5
   } face_type;

   // One classified word on its way from the front to the back
   typedef struct packed {
      logic                    is_query;
      logic                    solid;
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      y;
      logic [COORD_W-1:0]      z;
      logic [NFACE-1:0]        nb_in;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } cmd_type;

   function automatic logic [COORD_W-1:0] to_coord(input logic [VOX_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      return w[COORD_W-1:0];
   endfunction

endpackage

// ----- rtl/vfc_front.sv -----
// Front end: accept request words, drop those outside the chunk, classify the rest.
module vfc_front import vfc_pkg::*; (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // vox_x, vox_y, vox_z, voxel_value, zero pad
   input  logic                   req_tuser,   // command
   input  logic [EDGE_W-1:0]      chunk_edge,
   input  logic [ORIGIN_W-1:0]    origin_x,
   input  logic [ORIGIN_W-1:0]    origin_y,
   input  logic [ORIGIN_W-1:0]    origin_z,
   input  logic                   clear_busy,
   input  logic                   q_full,
   output logic                   q_push,
   output cmd_type                q_entry
);

   logic [VOX_W-1:0]   vx, vy, vz;
   logic [VALUE_W-1:0] value;
   logic [CMP_W-1:0]   edge_c, xc, yc, zc;
   logic               in_chunk;

   always_comb begin
      vx    = req_tdata[VOX_W-1:0];
      vy    = req_tdata[2*VOX_W-1:VOX_W];
      vz    = req_tdata[3*VOX_W-1:2*VOX_W];
      value = req_tdata[3*VOX_W+VALUE_W-1:3*VOX_W];

      // saturate the edge at the map size
      edge_c = CMP_W'(chunk_edge);
      if (edge_c > CMP_W'(MAX_EDGE)) begin
         edge_c = CMP_W'(MAX_EDGE);
      end
      xc = CMP_W'(vx);
      yc = CMP_W'(vy);
      zc = CMP_W'(vz);
      in_chunk = (xc < edge_c) && (yc < edge_c) && (zc < edge_c);

      q_entry.is_query = (req_tuser == CMD_QUERY);
      q_entry.solid    = (value != '0);
      q_entry.x        = to_coord(vx);
      q_entry.y        = to_coord(vy);
      q_entry.z        = to_coord(vz);
      q_entry.nb_in[FACE_LEFT]  = (vx != '0);
      q_entry.nb_in[FACE_RIGHT] = ((xc + CMP_W'(1)) < edge_c);
      q_entry.nb_in[FACE_DOWN]  = (vy != '0);
      q_entry.nb_in[FACE_UP]    = ((yc + CMP_W'(1)) < edge_c);
      q_entry.nb_in[FACE_FRONT] = (vz != '0);
      q_entry.nb_in[FACE_BACK]  = ((zc + CMP_W'(1)) < edge_c);
      q_entry.pos_x = {origin_x[ORIGIN_W-1], origin_x} + POS_W'(vx);
      q_entry.pos_y = {origin_y[ORIGIN_W-1], origin_y} + POS_W'(vy);
      q_entry.pos_z = {origin_z[ORIGIN_W-1], origin_z} + POS_W'(vz);

      req_tready = !q_full && !clear_busy;
      // drop anything outside the chunk: it never changes state or gives a result
      q_push     = req_tvalid && req_tready && in_chunk;
   end

endmodule

// ----- rtl/vfc_queue.sv -----
// Short queue between the front end and the back end.
module vfc_queue import vfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_entry,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      full      = (count_ff == CNT_W'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      pop_entry = entries_ff[rd_ptr_ff];
      wr_ptr_in = push ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/vfc_back.sv -----
// Back end: solid-bit row memory, load and query sequencer, result register.
module vfc_back import vfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  cmd_type                q_entry,
   output logic                   q_pop,
   output logic                   clear_busy,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [KIND_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_QREAD = 5'b01000,
      ST_EMIT  = 5'b10000
   } back_state_type;

   localparam logic [2:0] RD_CENTER = 3'd0;
   localparam logic [2:0] RD_DOWN   = 3'd1;
   localparam logic [2:0] RD_UP     = 3'd2;
   localparam logic [2:0] RD_FRONT  = 3'd3;
   localparam logic [2:0] RD_BACK   = 3'd4;

   logic [ROW_W-1:0]      mem [ROWS];
   logic [ROW_W-1:0]      rd_data_ff;

   back_state_type          state_ff, state_in;
   logic [ROW_ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   cmd_type                 cur_ff, cur_in;
   logic [2:0]              step_ff, step_in;
   logic [NFACE-1:0]        faces_ff, faces_in;

   logic                    out_valid_ff, out_valid_in;
   face_type                out_kind_ff, out_kind_in;
   logic signed [POS_W-1:0] out_pos_x_ff, out_pos_x_in;
   logic signed [POS_W-1:0] out_pos_y_ff, out_pos_y_in;
   logic signed [POS_W-1:0] out_pos_z_ff, out_pos_z_in;
   logic                    out_last_ff, out_last_in;

   logic                    rd_en, wr_en;
   logic [ROW_ADDR_W-1:0]   rd_addr, wr_addr;
   logic [ROW_W-1:0]        wr_data;
   logic                    out_load;
   logic                    bit_here, bit_left, bit_right;
   logic [KIND_W-1:0]       pick;
   logic [NFACE-1:0]        rest;

   always_comb begin
      bit_here  = rd_data_ff[cur_ff.x];
      bit_left  = rd_data_ff[cur_ff.x - COORD_W'(1)];
      bit_right = rd_data_ff[cur_ff.x + COORD_W'(1)];

      // lowest face still pending goes out first
      pick = '0;
      for (int i = NFACE - 1; i >= 0; i--) begin
         if (faces_ff[i]) begin
            pick = KIND_W'(i);
         end
      end
      rest       = faces_ff;
      rest[pick] = 1'b0;

      out_load = !out_valid_ff || rsp_tready;

      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      faces_in     = faces_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_pos_x_in = out_pos_x_ff;
      out_pos_y_in = out_pos_y_ff;
      out_pos_z_in = out_pos_z_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = {cur_ff.z, cur_ff.y};
      wr_en        = 1'b0;
      wr_addr      = {cur_ff.z, cur_ff.y};
      wr_data      = rd_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ROW_ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_entry;
               rd_en    = 1'b1;
               rd_addr  = {q_entry.z, q_entry.y};
               step_in  = RD_CENTER;
               faces_in = '0;
               state_in = q_entry.is_query ? ST_QREAD : ST_LOAD;
            end
         end
         ST_LOAD: begin
            // read-modify-write of the voxel's row
            wr_en             = 1'b1;
            wr_data[cur_ff.x] = cur_ff.solid;
            state_in          = ST_IDLE;
         end
         ST_QREAD: begin
            rd_en = 1'b1;
            case (step_ff)
               RD_CENTER: begin
                  faces_in[FACE_LEFT]  = !(bit_left && cur_ff.nb_in[FACE_LEFT]);
                  faces_in[FACE_RIGHT] = !(bit_right && cur_ff.nb_in[FACE_RIGHT]);
                  rd_addr = {cur_ff.z, cur_ff.y - COORD_W'(1)};
                  step_in = RD_DOWN;
                  if (!bit_here) begin
                     state_in = ST_IDLE;
                  end
               end
               RD_DOWN: begin
                  faces_in[FACE_DOWN] = !(bit_here && cur_ff.nb_in[FACE_DOWN]);
                  rd_addr = {cur_ff.z, cur_ff.y + COORD_W'(1)};
                  step_in = RD_UP;
               end
               RD_UP: begin
                  faces_in[FACE_UP] = !(bit_here && cur_ff.nb_in[FACE_UP]);
                  rd_addr = {cur_ff.z - COORD_W'(1), cur_ff.y};
                  step_in = RD_FRONT;
               end
               RD_FRONT: begin
                  faces_in[FACE_FRONT] = !(bit_here && cur_ff.nb_in[FACE_FRONT]);
                  rd_addr = {cur_ff.z + COORD_W'(1), cur_ff.y};
                  step_in = RD_BACK;
               end
               RD_BACK: begin
                  rd_en = 1'b0;
                  faces_in[FACE_BACK] = !(bit_here && cur_ff.nb_in[FACE_BACK]);
                  state_in = (faces_in == '0) ? ST_IDLE : ST_EMIT;
               end
               default: begin
                  rd_en    = 1'b0;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_kind_in  = face_type'(pick);
               out_pos_x_in = cur_ff.pos_x;
               out_pos_y_in = cur_ff.pos_y;
               case (face_type'(pick))
                  FACE_FRONT: out_pos_z_in = cur_ff.pos_z - POS_W'(1);
                  FACE_BACK:  out_pos_z_in = cur_ff.pos_z + POS_W'(1);
                  default:    out_pos_z_in = cur_ff.pos_z;
               endcase
               out_last_in = (rest == '0);
               faces_in    = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      clear_busy = (state_ff == ST_CLEAR);
      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {(RSP_TDATA_W - 3 * POS_W)'(0), out_pos_z_ff, out_pos_y_ff, out_pos_x_ff};
      rsp_tuser  = out_kind_ff;
      rsp_tlast  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= RD_CENTER;
         faces_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         faces_ff     <= faces_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_kind_ff  <= out_kind_in;
      out_pos_x_ff <= out_pos_x_in;
      out_pos_y_ff <= out_pos_y_in;
      out_pos_z_ff <= out_pos_z_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/voxel_face_culler_unit.sv -----
// Top level of the voxel face culler: configuration registers, front end, queue, back end.
//
// The block keeps one solid bit for every voxel of a cubic chunk of up to 32 voxels a side,
// stored as rows of 32 bits addressed by z and y in a single-port memory. After reset a
// clearing pass writes every row to zero, one row a cycle; req_tready stays low until it ends
// (configuration writes are taken throughout). A load word takes the back end through a row
// read, then a row write. A query word reads the centre row and the four neighbouring rows one
// after another from that one memory port, then sends one face record for each open face, held
// while the result side stalls; an empty voxel ends the query after the centre row. Words that
// name a voxel outside the chunk are dropped by the front end in the cycle they are accepted.
// A two-word queue lets the front end keep accepting while the back end is busy, and the result
// register holds one record while the back end prepares the next.
// Configuration is to be written only while the block is idle.
module voxel_face_culler_unit import vfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request words
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // vox_x[4:0], vox_y[9:5], vox_z[14:10],
                                               // voxel_value[22:15], zero pad [23]
   input  logic                   req_tuser,   // command
   // result words
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // pos_x[21:0], pos_y[43:22], pos_z[65:44],
                                               // zero pad [71:66]
   output logic [KIND_W-1:0]      rsp_tuser,   // face_kind
   output logic                   rsp_tlast,   // last_face
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_addr,
   input  logic [ORIGIN_W-1:0]    csr_wdata
);

   logic [EDGE_W-1:0]   chunk_edge_ff, chunk_edge_in;
   logic [ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic [ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [ORIGIN_W-1:0] origin_z_ff, origin_z_in;

   logic    clear_busy;
   logic    q_full, q_empty, q_push, q_pop;
   cmd_type push_entry, pop_entry;

   // register file: one write a cycle, no read-back
   always_comb begin
      chunk_edge_in = chunk_edge_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      origin_z_in   = origin_z_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CHUNK_EDGE: chunk_edge_in = csr_wdata[EDGE_W-1:0];
            CSR_ORIGIN_X:   origin_x_in   = csr_wdata;
            CSR_ORIGIN_Y:   origin_y_in   = csr_wdata;
            CSR_ORIGIN_Z:   origin_z_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_edge_ff <= EDGE_RESET;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         origin_z_ff   <= '0;
      end else begin
         chunk_edge_ff <= chunk_edge_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         origin_z_ff   <= origin_z_in;
      end
   end

   vfc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .chunk_edge (chunk_edge_ff),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .origin_z   (origin_z_ff),
      .clear_busy (clear_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   vfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (pop_entry)
   );

   vfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/vfc_checker.sv -----
// Port-level checks of the voxel face culler, bound to the top level.
module vfc_checker import vfc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]      rsp_tuser,
   input logic                   rsp_tlast
);

   // hold off requests and results straight after reset, when the map clearing starts
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request or result active straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= FACE_BACK)
      else $error("face kind out of range");

   // the back face, when sent, comes last in its query
   a_back_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == FACE_BACK |-> rsp_tlast)
      else $error("back face not marked last");

endmodule

bind voxel_face_culler_unit vfc_checker u_vfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the voxel face culler: loads, face queries and register settings.
`timescale 1ns / 1ps

module testbench;
   import vfc_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_TICKS = 40;     // a load leaves no result; let the queue empty out
   localparam int REPORT_MAX   = 10;

   // one face record as it leaves the block
   typedef struct packed {
      face_type          kind;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
      logic              last;
   } face_rec_type;

   // Scoreboard: own copy of the solid map and registers, predicts the faces of each query
   class face_scoreboard_type;
      bit                 solid_map [MAX_EDGE*MAX_EDGE*MAX_EDGE];
      logic [EDGE_W-1:0]  chunk_edge;
      logic [ORIGIN_W-1:0] org_x, org_y, org_z;
      face_rec_type       face_fifo [$];
      int                 mismatches;

      function new();
         foreach (solid_map[i]) solid_map[i] = 1'b0;
         chunk_edge = EDGE_RESET;
         org_x = '0;
         org_y = '0;
         org_z = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [ORIGIN_W-1:0] value);
         case (idx)
            CSR_CHUNK_EDGE: chunk_edge = value[EDGE_W-1:0];
            CSR_ORIGIN_X:   org_x = value;
            CSR_ORIGIN_Y:   org_y = value;
            CSR_ORIGIN_Z:   org_z = value;
            default: ;
         endcase
      endfunction

      function int span();
         return (chunk_edge > MAX_EDGE) ? MAX_EDGE : int'(chunk_edge);
      endfunction

      function bit in_chunk(int x, int y, int z);
         int e;
         e = span();
         return x >= 0 && y >= 0 && z >= 0 && x < e && y < e && z < e;
      endfunction

      function bit solid_at(int x, int y, int z);
         if (!in_chunk(x, y, z)) return 1'b0;
         return solid_map[(z * MAX_EDGE + y) * MAX_EDGE + x];
      endfunction

      function int outstanding();
         return face_fifo.size();
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
      endfunction

      // note one accepted request word and queue the faces it causes
      function void note_word(cmd_code_type cmd, logic [VOX_W-1:0] x, logic [VOX_W-1:0] y,
                              logic [VOX_W-1:0] z, logic [VALUE_W-1:0] value);
         logic [NFACE-1:0] open_faces;
         logic [POS_W-1:0] bx, by, bz;
         face_rec_type     rec;
         int               nx, ny, nz;
         if (!in_chunk(x, y, z)) return;
         if (cmd == CMD_LOAD) begin
            solid_map[(int'(z) * MAX_EDGE + int'(y)) * MAX_EDGE + int'(x)] = (value != '0);
            return;
         end
         if (!solid_at(x, y, z)) return;
         for (int k = 0; k < NFACE; k++) begin
            nx = x;
            ny = y;
            nz = z;
            case (face_type'(k))
               FACE_LEFT:  nx = nx - 1;
               FACE_RIGHT: nx = nx + 1;
               FACE_DOWN:  ny = ny - 1;
               FACE_UP:    ny = ny + 1;
               FACE_FRONT: nz = nz - 1;
               default:    nz = nz + 1;
            endcase
            open_faces[k] = !solid_at(nx, ny, nz);
         end
         // sign-extend the origin, then wrap at the position width
         bx = {org_x[ORIGIN_W-1], org_x} + POS_W'(x);
         by = {org_y[ORIGIN_W-1], org_y} + POS_W'(y);
         bz = {org_z[ORIGIN_W-1], org_z} + POS_W'(z);
         for (int k = 0; k < NFACE; k++) begin
            if (open_faces[k]) begin
               rec.kind  = face_type'(k);
               rec.pos_x = bx;
               rec.pos_y = by;
               rec.pos_z = (rec.kind == FACE_FRONT) ? bz - 1'b1 :
                           (rec.kind == FACE_BACK)  ? bz + 1'b1 : bz;
               rec.last  = ((open_faces >> (k + 1)) == '0);
               face_fifo.push_back(rec);
            end
         end
      endfunction

      function void check_face(face_rec_type seen);
         face_rec_type want;
         if (face_fifo.size() == 0) begin
            flag($sformatf("face record with none due: kind %0d pos %0d,%0d,%0d last %0b",
                           seen.kind, $signed(seen.pos_x), $signed(seen.pos_y),
                           $signed(seen.pos_z), seen.last));
            return;
         end
         want = face_fifo.pop_front();
         if (seen !== want)
            flag($sformatf({"expected kind %0d pos %0d,%0d,%0d last %0b, ",
                            "got kind %0d pos %0d,%0d,%0d last %0b"},
                           want.kind, $signed(want.pos_x), $signed(want.pos_y),
                           $signed(want.pos_z), want.last, seen.kind, $signed(seen.pos_x),
                           $signed(seen.pos_y), $signed(seen.pos_z), seen.last));
      endfunction

      function void close_out();
         while (face_fifo.size() != 0) begin
            flag($sformatf("face record never arrived: kind %0d", face_fifo[0].kind));
            void'(face_fifo.pop_front());
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr = '0;
   logic [ORIGIN_W-1:0]    csr_wdata = '0;

   face_scoreboard_type book = new();
   bit             quiet_tail = 1'b0;   // no idling on either side once set
   int             cycle_count = 0;
   logic [3*VOX_W-1:0] loaded_spots [$]; // voxels loaded solid in this phase, {z, y, x}

   voxel_face_culler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run with a failure once the cycle limit is reached
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   // Result side: check every accepted word, stall in short random bursts
   initial begin
      int           stall_left;
      face_rec_type seen;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            seen.kind  = face_type'(rsp_tuser);
            seen.pos_x = rsp_tdata[POS_W-1:0];
            seen.pos_y = rsp_tdata[2*POS_W-1:POS_W];
            seen.pos_z = rsp_tdata[3*POS_W-1:2*POS_W];
            seen.last  = rsp_tlast;
            book.check_face(seen);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one request word, hold it until taken, then note it with the scoreboard.
   // tvalid stays high on return so back-to-back words need no second assignment.
   task automatic send_word(input cmd_code_type cmd, input logic [VOX_W-1:0] x,
                            input logic [VOX_W-1:0] y, input logic [VOX_W-1:0] z,
                            input logic [VALUE_W-1:0] value);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, value, z, y, x};
      do @(posedge clock); while (!req_tready);
      book.note_word(cmd, x, y, z, value);
   endtask

   // Drop tvalid, wait for every face due, then let trailing loads settle
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Write all four registers in turn; junk above the edge field is masked
   task automatic program_regs(input logic [EDGE_W-1:0] edge_len,
                               input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy,
                               input logic [ORIGIN_W-1:0] oz);
      logic [CSR_IDX_W-1:0] idxs [4];
      logic [ORIGIN_W-1:0]  vals [4];
      idxs = '{CSR_CHUNK_EDGE, CSR_ORIGIN_X, CSR_ORIGIN_Y, CSR_ORIGIN_Z};
      vals = '{{(ORIGIN_W - EDGE_W)'($urandom()), edge_len}, ox, oy, oz};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         book.set_reg(idxs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Random words mostly aimed at a cube up to 3 voxels a side, often at the x=0 or top y wall,
   // queries mostly hitting voxels loaded solid earlier; the rest is noise over all 32 codes.
   task automatic random_words(input int count);
      int                 e, width, bx, by, bz;
      logic [VOX_W-1:0]   x, y, z;
      logic [VALUE_W-1:0] value;
      logic [3*VOX_W-1:0] spot;
      cmd_code_type       cmd;
      e     = book.span();
      width = (e < 3) ? e : 3;
      bx = 0;
      by = 0;
      bz = 0;
      if (e > 0) begin
         bx = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, e - width);
         by = ($urandom_range(0, 2) == 0) ? e - width : $urandom_range(0, e - width);
         bz = $urandom_range(0, e - width);
      end
      loaded_spots.delete();
      repeat (count) begin
         value = ($urandom_range(0, 4) == 0) ? '0 : VALUE_W'($urandom_range(1, 255));
         cmd   = ($urandom_range(0, 9) < 5) ? CMD_LOAD : CMD_QUERY;
         if (e == 0 || $urandom_range(0, 9) < 2) begin
            cmd = cmd_code_type'($urandom_range(0, 1));
            x = VOX_W'($urandom());
            y = VOX_W'($urandom());
            z = VOX_W'($urandom());
            value = VALUE_W'($urandom());
         end else if (cmd == CMD_QUERY && loaded_spots.size() != 0
                      && $urandom_range(0, 2) != 0) begin
            spot = loaded_spots[$urandom_range(0, loaded_spots.size() - 1)];
            {z, y, x} = spot;
         end else begin
            x = VOX_W'(bx + $urandom_range(0, width - 1));
            y = VOX_W'(by + $urandom_range(0, width - 1));
            z = VOX_W'(bz + $urandom_range(0, width - 1));
            if (cmd == CMD_LOAD && value != '0) loaded_spots.push_back({z, y, x});
         end
         send_word(cmd, x, y, z, value);
      end
   endtask

   // Main sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings: 16 voxels a side, origin at zero
      send_word(CMD_QUERY, 5'd0,  5'd0,  5'd0,  8'h00);   // empty voxel: nothing
      send_word(CMD_LOAD,  5'd0,  5'd0,  5'd0,  8'hFF);
      send_word(CMD_QUERY, 5'd0,  5'd0,  5'd0,  8'h00);   // all six faces, three at the wall
      send_word(CMD_LOAD,  5'd1,  5'd0,  5'd0,  8'h01);
      send_word(CMD_QUERY, 5'd0,  5'd0,  5'd0,  8'hFF);   // right face hidden
      send_word(CMD_LOAD,  5'd31, 5'd31, 5'd31, 8'h80);   // outside the chunk: dropped
      send_word(CMD_QUERY, 5'd31, 5'd31, 5'd31, 8'h00);   // outside: nothing
      send_word(CMD_LOAD,  5'd15, 5'd15, 5'd15, 8'h55);
      send_word(CMD_QUERY, 5'd15, 5'd15, 5'd15, 8'h00);   // far corner, walls count as empty
      send_word(CMD_LOAD,  5'd0,  5'd0,  5'd0,  8'h00);   // clear again
      send_word(CMD_QUERY, 5'd0,  5'd0,  5'd0,  8'h00);   // now empty
      send_word(CMD_QUERY, 5'd1,  5'd0,  5'd0,  8'h00);   // left neighbour cleared: six faces
      // fully enclosed voxel: no face at all
      send_word(CMD_LOAD,  5'd5,  5'd5,  5'd5,  8'hAA);
      send_word(CMD_LOAD,  5'd4,  5'd5,  5'd5,  8'h02);
      send_word(CMD_LOAD,  5'd6,  5'd5,  5'd5,  8'h04);
      send_word(CMD_LOAD,  5'd5,  5'd4,  5'd5,  8'h08);
      send_word(CMD_LOAD,  5'd5,  5'd6,  5'd5,  8'h10);
      send_word(CMD_LOAD,  5'd5,  5'd5,  5'd4,  8'h20);
      send_word(CMD_LOAD,  5'd5,  5'd5,  5'd6,  8'h40);
      send_word(CMD_QUERY, 5'd5,  5'd5,  5'd5,  8'hAA);
      send_word(CMD_QUERY, 5'd5,  5'd4,  5'd5,  8'h00);   // up face hidden
      send_word(CMD_QUERY, 5'd5,  5'd5,  5'd6,  8'h00);   // front face hidden
      drain_block();

      // Full-size chunk at the most negative origin
      program_regs(6'd32, 21'h100000, 21'h100000, 21'h100000);
      random_words(14);
      drain_block();

      // Single-voxel chunk at the most positive origin: only voxel 0,0,0 lives
      program_regs(6'd1, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF);
      send_word(CMD_LOAD,  5'd0, 5'd0, 5'd0, 8'h01);
      send_word(CMD_QUERY, 5'd0, 5'd0, 5'd0, 8'h00);
      random_words(12);
      drain_block();

      // Zero edge: every word is dropped
      program_regs(6'd0, ORIGIN_W'($urandom()), ORIGIN_W'($urandom()), ORIGIN_W'($urandom()));
      random_words(8);
      drain_block();

      // Edge beyond the map saturates at full size
      program_regs(6'd63, ORIGIN_W'($urandom()), ORIGIN_W'($urandom()), ORIGIN_W'($urandom()));
      send_word(CMD_LOAD,  5'd31, 5'd31, 5'd31, 8'h7F);
      send_word(CMD_QUERY, 5'd31, 5'd31, 5'd31, 8'h00);
      random_words(14);
      drain_block();

      // Random mid-size edge; the bits left outside earlier stay hidden
      program_regs(EDGE_W'($urandom_range(2, 31)), ORIGIN_W'($urandom()),
                   ORIGIN_W'($urandom()), ORIGIN_W'($urandom()));
      random_words(14);
      drain_block();

      // Last stretch back at reset settings with both sides running flat out
      quiet_tail = 1'b1;
      program_regs(EDGE_RESET, '0, '0, '0);
      random_words(14);
      drain_block();

      book.close_out();
      if (book.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
